### rtl/qrpack_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR segment packer package
// Shared codes, widths and the structs passed between the packer modules.
// ----------------------------------------------------------------------------
package qrpack_pkg;

  localparam int unsigned CAP_W  = 12;
  localparam int unsigned APP_W  = 20;   // widest single append: 4 + 16 bits
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned BUF_W  = 7;    // pending bits never reach a byte
  localparam int unsigned FILL_W = 3;
  localparam int unsigned GV_W   = 11;
  localparam int unsigned MAX_BYTES = 3;

  localparam logic [CAP_W-1:0] MAX_CAPACITY = 12'd2956;

  localparam logic [3:0] IND_NUMERIC = 4'b0001;
  localparam logic [3:0] IND_ALNUM   = 4'b0010;
  localparam logic [3:0] IND_BYTE    = 4'b0100;

  localparam logic [7:0] PAD_BYTE_EVEN = 8'hEC;
  localparam logic [7:0] PAD_BYTE_ODD  = 8'h11;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_CHAR   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_PAD    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_CNT_NUMERIC = 2'd0,
    REG_CNT_ALNUM   = 2'd1,
    REG_CNT_BYTE    = 2'd2,
    REG_CAPACITY    = 2'd3
  } reg_e;

  // Bits one input word adds to the stream, right aligned.
  typedef struct packed {
    logic [APP_W-1:0] val;
    logic [LEN_W-1:0] len;
    logic             finish;   // zero fill to the next byte boundary
  } append_t;

  // Up to three codewords produced by one input word.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [1:0]                count;
    logic [MAX_BYTES-1:0]      done;
    logic [MAX_BYTES-1:0]      ovf;
    logic                      bad;
  } burst_t;

endpackage

### rtl/qrpack_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR segment packer command encoder
// Turns one command word into the bits it appends and the next group state.
// ----------------------------------------------------------------------------
module qrpack_encoder (
  input  qrpack_pkg::cmd_e                     cmd_i,
  input  logic [1:0]                           seg_mode_i,
  input  logic [15:0]                          char_count_i,
  input  logic [7:0]                           char_value_i,
  input  qrpack_pkg::mode_e                    mode_i,
  input  logic [qrpack_pkg::GV_W-1:0]          group_value_i,
  input  logic [1:0]                           group_chars_i,
  input  logic [qrpack_pkg::FILL_W-1:0]        fill_i,
  input  logic                                 pad_phase_i,
  input  logic                                 room_i,
  input  logic [3:0]                           cnt_bits_numeric_i,
  input  logic [3:0]                           cnt_bits_alnum_i,
  input  logic [4:0]                           cnt_bits_byte_i,
  output qrpack_pkg::append_t                  app_o,
  output qrpack_pkg::mode_e                    mode_o,
  output logic [qrpack_pkg::GV_W-1:0]          group_value_o,
  output logic [1:0]                           group_chars_o,
  output logic                                 pad_phase_o,
  output logic                                 bad_o
);
  import qrpack_pkg::*;

  // Returns {valid, code} for the 45-character alphanumeric set.
  function automatic logic [6:0] alnum_code(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 6'(c - "0")};
    end else if (c >= "A" && c <= "Z") begin
      r = {1'b1, 6'(c - "A" + 8'd10)};
    end else begin
      case (c)
        " ":     r = {1'b1, 6'd36};
        "$":     r = {1'b1, 6'd37};
        "%":     r = {1'b1, 6'd38};
        "*":     r = {1'b1, 6'd39};
        "+":     r = {1'b1, 6'd40};
        "-":     r = {1'b1, 6'd41};
        ".":     r = {1'b1, 6'd42};
        "/":     r = {1'b1, 6'd43};
        ":":     r = {1'b1, 6'd44};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  logic [3:0]       ind;
  logic [4:0]       cw;
  logic [APP_W-1:0] cnt_mask;
  logic             digit_ok;
  logic [3:0]       digit;
  logic [13:0]      times10;
  logic [GV_W-1:0]  num_next;
  logic [6:0]       acode;
  logic [16:0]      times45;
  logic [GV_W-1:0]  an_next;
  logic [LEN_W-1:0] flush_len;
  logic [GV_W-1:0]  flush_val;

  always_comb begin
    app_o         = '0;
    mode_o        = mode_i;
    group_value_o = group_value_i;
    group_chars_o = group_chars_i;
    pad_phase_o   = pad_phase_i;
    bad_o         = 1'b0;
    ind           = IND_BYTE;
    cw            = '0;
    cnt_mask      = '0;
    digit_ok      = (char_value_i >= "0") && (char_value_i <= "9");
    digit         = digit_ok ? 4'(char_value_i - "0") : 4'd0;
    times10       = {group_value_i, 3'b000} + {2'b00, group_value_i, 1'b0};
    num_next      = times10[GV_W-1:0] + {7'd0, digit};
    acode         = alnum_code(char_value_i);
    times45       = {1'b0, group_value_i, 5'd0} + {3'b0, group_value_i, 3'd0}
                  + {4'b0, group_value_i, 2'd0} + {6'd0, group_value_i};
    an_next       = times45[GV_W-1:0] + {5'd0, acode[5:0]};
    flush_len     = '0;
    flush_val     = '0;

    unique case (cmd_i)
      CMD_START: begin
        case (seg_mode_i)
          MODE_NUMERIC: begin
            mode_o = MODE_NUMERIC;
            ind    = IND_NUMERIC;
            cw     = {1'b0, cnt_bits_numeric_i};
          end
          MODE_ALNUM: begin
            mode_o = MODE_ALNUM;
            ind    = IND_ALNUM;
            cw     = {1'b0, cnt_bits_alnum_i};
          end
          default: begin
            // mode code three falls back to byte mode
            mode_o = MODE_BYTE;
            ind    = IND_BYTE;
            cw     = (cnt_bits_byte_i > 5'd16) ? 5'd16 : cnt_bits_byte_i;
          end
        endcase
        cnt_mask      = ~({APP_W{1'b1}} << cw);
        app_o.val     = ({16'd0, ind} << cw) | ({4'd0, char_count_i} & cnt_mask);
        app_o.len     = 5'd4 + cw;
        group_value_o = '0;
        group_chars_o = '0;
      end
      CMD_CHAR: begin
        case (mode_i)
          MODE_NUMERIC: begin
            bad_o = !digit_ok;
            if (group_chars_i == 2'd2) begin
              app_o.val     = {10'd0, num_next[9:0]};
              app_o.len     = 5'd10;
              group_value_o = '0;
              group_chars_o = '0;
            end else begin
              group_value_o = num_next;
              group_chars_o = group_chars_i + 2'd1;
            end
          end
          MODE_ALNUM: begin
            bad_o = !acode[6];
            if (group_chars_i == 2'd1) begin
              app_o.val     = {9'd0, an_next};
              app_o.len     = 5'd11;
              group_value_o = '0;
              group_chars_o = '0;
            end else begin
              group_value_o = an_next;
              group_chars_o = group_chars_i + 2'd1;
            end
          end
          default: begin
            app_o.val = {12'd0, char_value_i};
            app_o.len = 5'd8;
          end
        endcase
      end
      CMD_FINISH: begin
        // partial group, then the four-bit terminator
        case (mode_i)
          MODE_NUMERIC: begin
            if (group_chars_i == 2'd1) begin
              flush_len = 5'd4;
              flush_val = group_value_i & 11'h00F;
            end else if (group_chars_i == 2'd2) begin
              flush_len = 5'd7;
              flush_val = group_value_i & 11'h07F;
            end
          end
          MODE_ALNUM: begin
            if (group_chars_i != 2'd0) begin
              flush_len = 5'd6;
              flush_val = group_value_i & 11'h03F;
            end
          end
          default: begin
            flush_len = '0;
          end
        endcase
        app_o.val     = {5'd0, flush_val, 4'd0};
        app_o.len     = flush_len + 5'd4;
        app_o.finish  = 1'b1;
        group_value_o = '0;
        group_chars_o = '0;
      end
      CMD_PAD: begin
        if (fill_i == '0 && room_i) begin
          app_o.val   = {12'd0, pad_phase_i ? PAD_BYTE_ODD : PAD_BYTE_EVEN};
          app_o.len   = 5'd8;
          pad_phase_o = !pad_phase_i;
        end
      end
      default: begin
        app_o = '0;
      end
    endcase
  end

endmodule

### rtl/qrpack_slicer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR segment packer byte slicer
// Joins pending bits with new bits and cuts whole codewords, MSB first.
// ----------------------------------------------------------------------------
module qrpack_slicer (
  input  logic [qrpack_pkg::BUF_W-1:0]                 buf_i,
  input  logic [qrpack_pkg::FILL_W-1:0]                fill_i,
  input  qrpack_pkg::append_t                          app_i,
  output logic [qrpack_pkg::MAX_BYTES-1:0][7:0]        data_o,
  output logic [1:0]                                   count_o,
  output logic [qrpack_pkg::BUF_W-1:0]                 buf_o,
  output logic [qrpack_pkg::FILL_W-1:0]                fill_o
);
  import qrpack_pkg::*;

  logic [31:0] w;
  logic [31:0] al;
  logic [5:0]  len;
  logic [3:0]  pad;

  always_comb begin
    w   = ({25'd0, buf_i} << app_i.len) | {12'd0, app_i.val};
    len = {3'd0, fill_i} + {1'b0, app_i.len};
    pad = '0;
    // finish rounds up to a byte boundary with zeros
    if (app_i.finish && len[2:0] != 3'd0) begin
      pad = 4'd8 - {1'b0, len[2:0]};
      w   = w << pad;
      len = len + {2'd0, pad};
    end
    al        = w << (6'd32 - len);
    data_o[0] = al[31:24];
    data_o[1] = al[23:16];
    data_o[2] = al[15:8];
    count_o   = len[4:3];
    fill_o    = len[2:0];
    buf_o     = w[BUF_W-1:0] & ~({BUF_W{1'b1}} << len[2:0]);
  end

endmodule

### rtl/qrpack_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR segment packer output burst register
// Holds the codewords of one input word and hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module qrpack_burst (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  qrpack_pkg::burst_t burst_i,
  output logic               free_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [7:0]         m_tdata_o,   // [7:0] out_byte
  output logic               m_tlast_o,
  output logic [2:0]         m_tuser_o    // [0] symbol_done, [1] overflow, [2] bad_char
);
  import qrpack_pkg::*;

  logic   valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  burst_t burst_q;
  logic   last;
  logic   take;

  assign last       = (idx_q == burst_q.count - 2'd1);
  assign take       = valid_q && m_tready_i;
  assign free_o     = !valid_q || (take && last);
  assign m_tvalid_o = valid_q;
  assign m_tlast_o  = last;

  always_comb begin
    case (idx_q)
      2'd0:    m_tdata_o = burst_q.data[0];
      2'd1:    m_tdata_o = burst_q.data[1];
      default: m_tdata_o = burst_q.data[2];
    endcase
    case (idx_q)
      2'd0:    m_tuser_o = {burst_q.bad, burst_q.ovf[0], burst_q.done[0]};
      2'd1:    m_tuser_o = {burst_q.bad, burst_q.ovf[1], burst_q.done[1]};
      default: m_tuser_o = {burst_q.bad, burst_q.ovf[2], burst_q.done[2]};
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take && last) begin
      valid_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

### rtl/qr_data_segment_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR data segment bit packer
// Packs numeric, alphanumeric and byte segments into QR data codewords.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_* stream: tuser carries the command (start,
//   character, finish, pad) and the segment mode, tdata the character count
//   and the character value. Each word yields zero to three codeword words on
//   the m_* stream, MSB first; tlast marks the last codeword a word caused,
//   tuser carries symbol_done and the sticky overflow and bad_char flags.
//   Count field widths and symbol capacity sit behind the APB port; write
//   them only while the block is idle.
// Timing:
//   A word is decoded and sliced in its accept cycle; its codewords are
//   valid on m_* the next cycle and leave one per cycle while m_tready is
//   high. The next word is taken in the cycle the last codeword of the
//   previous one leaves: one word per cycle while m_tready holds for words
//   yielding one codeword, while a word yielding up to three holds off the
//   next until its last leaves, bounded by the byte-wide output port.
// Reset clears all segment state, flags and counters and loads the register
// defaults. When the receiver stalls, hold the current codeword and refuse
// new input words until the burst drains.
// ----------------------------------------------------------------------------
module qr_data_segment_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [15:0] char_count, [23:16] char_value
  input  logic [3:0]  s_tuser_i,   // [1:0] cmd, [3:2] seg_mode
  // codeword stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,   // [7:0] out_byte
  output logic        m_tlast_o,
  output logic [2:0]  m_tuser_o,   // [0] symbol_done, [1] overflow, [2] bad_char
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qrpack_pkg::*;

  // configuration registers
  logic [3:0]       cnt_num_q;
  logic [3:0]       cnt_alnum_q;
  logic [4:0]       cnt_byte_q;
  logic [CAP_W-1:0] cap_q;

  // segment state
  mode_e             mode_q, mode_d;
  logic [GV_W-1:0]   gv_q, gv_d;
  logic [1:0]        gc_q, gc_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CAP_W-1:0]  be_q, be_d;
  logic              pad_q, pad_d;
  logic              ovf_q, ovf_d;
  logic              bad_q, bad_d;

  logic              s_accept;
  logic              cfg_write;
  reg_e              reg_sel;
  logic [CAP_W-1:0]  cap_eff;
  logic              room;
  logic              bad_set;
  append_t           app;
  logic [MAX_BYTES-1:0][7:0] bytes;
  logic [1:0]        nbytes;
  logic [CAP_W:0]    pos;
  logic [CAP_W:0]    sum;
  burst_t            burst;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite;
  assign reg_sel    = reg_e'(paddr[3:2]);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign cap_eff    = (cap_q > MAX_CAPACITY) ? MAX_CAPACITY : cap_q;
  assign room       = be_q < cap_eff;

  // Register read back
  always_comb begin
    unique case (reg_sel)
      REG_CNT_NUMERIC: prdata = {28'd0, cnt_num_q};
      REG_CNT_ALNUM:   prdata = {28'd0, cnt_alnum_q};
      REG_CNT_BYTE:    prdata = {27'd0, cnt_byte_q};
      REG_CAPACITY:    prdata = {20'd0, cap_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_num_q   <= 4'd14;
      cnt_alnum_q <= 4'd13;
      cnt_byte_q  <= 5'd16;
      cap_q       <= 12'd2956;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CNT_NUMERIC: cnt_num_q   <= pwdata[3:0];
        REG_CNT_ALNUM:   cnt_alnum_q <= pwdata[3:0];
        REG_CNT_BYTE:    cnt_byte_q  <= pwdata[4:0];
        REG_CAPACITY:    cap_q       <= pwdata[CAP_W-1:0];
        default:         cap_q       <= cap_q;
      endcase
    end
  end

  qrpack_encoder u_encoder (
    .cmd_i              (cmd_e'(s_tuser_i[1:0])),
    .seg_mode_i         (s_tuser_i[3:2]),
    .char_count_i       (s_tdata_i[15:0]),
    .char_value_i       (s_tdata_i[23:16]),
    .mode_i             (mode_q),
    .group_value_i      (gv_q),
    .group_chars_i      (gc_q),
    .fill_i             (fill_q),
    .pad_phase_i        (pad_q),
    .room_i             (room),
    .cnt_bits_numeric_i (cnt_num_q),
    .cnt_bits_alnum_i   (cnt_alnum_q),
    .cnt_bits_byte_i    (cnt_byte_q),
    .app_o              (app),
    .mode_o             (mode_d),
    .group_value_o      (gv_d),
    .group_chars_o      (gc_d),
    .pad_phase_o        (pad_d),
    .bad_o              (bad_set)
  );

  qrpack_slicer u_slicer (
    .buf_i   (buf_q),
    .fill_i  (fill_q),
    .app_i   (app),
    .data_o  (bytes),
    .count_o (nbytes),
    .buf_o   (buf_d),
    .fill_o  (fill_d)
  );

  // Per-codeword capacity check: a codeword past capacity still goes out,
  // flags overflow and is not counted.
  always_comb begin
    pos         = '0;
    burst.data  = bytes;
    burst.count = nbytes;
    burst.bad   = bad_q || bad_set;
    for (int k = 0; k < MAX_BYTES; k++) begin
      pos           = {1'b0, be_q} + (CAP_W+1)'(k);
      burst.ovf[k]  = ovf_q || (pos >= {1'b0, cap_eff});
      burst.done[k] = (pos < {1'b0, cap_eff}) && (pos + 13'd1 == {1'b0, cap_eff});
    end
    sum   = {1'b0, be_q} + {11'd0, nbytes};
    bad_d = bad_q || bad_set;
    // any codeword of this word landing past capacity raises overflow
    ovf_d = ovf_q || ((nbytes != 2'd0) && (sum > {1'b0, cap_eff}));
    if (!room) begin
      be_d = be_q;
    end else if (sum >= {1'b0, cap_eff}) begin
      be_d = cap_eff;
    end else begin
      be_d = sum[CAP_W-1:0];
    end
  end

  // Advance segment state on every accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NUMERIC;
      gv_q   <= '0;
      gc_q   <= '0;
      buf_q  <= '0;
      fill_q <= '0;
      be_q   <= '0;
      pad_q  <= 1'b0;
      ovf_q  <= 1'b0;
      bad_q  <= 1'b0;
    end else if (s_accept) begin
      mode_q <= mode_d;
      gv_q   <= gv_d;
      gc_q   <= gc_d;
      buf_q  <= buf_d;
      fill_q <= fill_d;
      be_q   <= be_d;
      pad_q  <= pad_d;
      ovf_q  <= ovf_d;
      bad_q  <= bad_d;
    end
  end

  qrpack_burst u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s_accept && (nbytes != 2'd0)),
    .burst_i    (burst),
    .free_o     (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

### tb/sv/qr_packer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR segment packer checker
// Watches the word stream, the codeword stream and the APB port, predicts the
// codewords each accepted word yields, and counts every mismatch.
// ----------------------------------------------------------------------------
module qr_packer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // [15:0] char_count, [23:16] char_value
  input  logic [3:0]  s_tuser_i,   // [1:0] cmd, [3:2] seg_mode
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,   // [7:0] out_byte
  input  logic        m_tlast_i,
  input  logic [2:0]  m_tuser_i,   // [0] symbol_done, [1] overflow, [2] bad_char
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          pending_o,
  output int          errors_o
);
  import qrpack_pkg::*;

  localparam string ALNUM_EXTRA = " $%*+-./:";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       ovf;
    logic       bad;
  } codeword_t;

  codeword_t   codeword_q[$];   // codewords still owed by the block
  codeword_t   burst_q[$];      // codewords of the word being packed

  // Register copies
  logic [3:0]  cnt_bits_num;
  logic [3:0]  cnt_bits_aln;
  logic [4:0]  cnt_bits_byt;
  logic [11:0] cap_reg;

  // Segment state
  mode_e       seg_mode;
  int unsigned grp_val;
  int unsigned grp_cnt;
  logic [31:0] bit_buf;
  int unsigned bit_fill;
  logic [11:0] emitted;
  logic        pad_odd;
  logic        ovf_flag;
  logic        bad_flag;

  function automatic logic [11:0] usable_cap();
    return (cap_reg < MAX_CAPACITY) ? cap_reg : MAX_CAPACITY;
  endfunction

  function automatic int alnum_code(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
    for (int i = 0; i < 9; i++) begin
      if (ALNUM_EXTRA[i] == c) return 36 + i;
    end
    return -1;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    codeword_t cw;
    cw.done = 1'b0;
    if (emitted >= usable_cap()) begin
      ovf_flag = 1'b1;
    end else begin
      emitted = emitted + 12'd1;
      cw.done = (emitted == usable_cap());
    end
    cw.data = b;
    cw.last = 1'b0;
    cw.ovf  = ovf_flag;
    cw.bad  = bad_flag;
    burst_q.push_back(cw);
  endtask

  // Append n bits MSB first and cut off every full byte.
  task automatic shift_in(input logic [31:0] v, input int unsigned n);
    if (n != 0) begin
      bit_buf  = (bit_buf << n) | (v & ((32'd1 << n) - 32'd1));
      bit_fill = bit_fill + n;
      while (bit_fill >= 8) begin
        emit_byte(8'(bit_buf >> (bit_fill - 8)));
        bit_fill = bit_fill - 8;
        bit_buf  = bit_buf & ((32'd1 << bit_fill) - 32'd1);
      end
    end
  endtask

  task automatic pack_word(input cmd_e cmd, input logic [1:0] mode_bits,
                           input logic [15:0] count, input logic [7:0] ch);
    mode_e       m;
    int unsigned width;
    int          code;
    codeword_t   cw;
    case (cmd)
      CMD_START: begin
        // reserved mode code falls back to byte mode
        m = (mode_bits > MODE_BYTE) ? MODE_BYTE : mode_e'(mode_bits);
        seg_mode = m;
        grp_val  = 0;
        grp_cnt  = 0;
        case (m)
          MODE_NUMERIC: width = cnt_bits_num;
          MODE_ALNUM:   width = cnt_bits_aln;
          default:      width = cnt_bits_byt;
        endcase
        if (width > 16) width = 16;
        case (m)
          MODE_NUMERIC: shift_in({28'd0, IND_NUMERIC}, 4);
          MODE_ALNUM:   shift_in({28'd0, IND_ALNUM}, 4);
          default:      shift_in({28'd0, IND_BYTE}, 4);
        endcase
        shift_in({16'd0, count}, width);
      end
      CMD_CHAR: begin
        case (seg_mode)
          MODE_NUMERIC: begin
            code = 0;
            if (ch >= "0" && ch <= "9") code = int'(ch - "0");
            else bad_flag = 1'b1;
            grp_val = (grp_val * 10 + code) & 32'h7FF;
            grp_cnt++;
            if (grp_cnt == 3) begin
              shift_in(grp_val, 10);
              grp_val = 0;
              grp_cnt = 0;
            end
          end
          MODE_ALNUM: begin
            code = alnum_code(ch);
            if (code < 0) begin
              bad_flag = 1'b1;
              code = 0;
            end
            grp_val = (grp_val * 45 + code) & 32'h7FF;
            grp_cnt++;
            if (grp_cnt == 2) begin
              shift_in(grp_val, 11);
              grp_val = 0;
              grp_cnt = 0;
            end
          end
          default: shift_in({24'd0, ch}, 8);
        endcase
      end
      CMD_FINISH: begin
        if (grp_cnt != 0) begin
          if (seg_mode == MODE_NUMERIC) shift_in(grp_val, (grp_cnt == 1) ? 4 : 7);
          else if (seg_mode == MODE_ALNUM) shift_in(grp_val, 6);
          grp_val = 0;
          grp_cnt = 0;
        end
        shift_in(32'd0, 4);
        if (bit_fill != 0) shift_in(32'd0, 8 - bit_fill);
      end
      default: begin
        // pad only on a byte boundary and below capacity
        if (bit_fill == 0 && emitted < usable_cap()) begin
          emit_byte(pad_odd ? PAD_BYTE_ODD : PAD_BYTE_EVEN);
          pad_odd = ~pad_odd;
        end
      end
    endcase
    while (burst_q.size() > 0) begin
      cw = burst_q.pop_front();
      cw.last = (burst_q.size() == 0);
      codeword_q.push_back(cw);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    codeword_t want;
    if (!rst_ni) begin
      cnt_bits_num = 4'd14;
      cnt_bits_aln = 4'd13;
      cnt_bits_byt = 5'd16;
      cap_reg      = MAX_CAPACITY;
      seg_mode     = MODE_NUMERIC;
      grp_val      = 0;
      grp_cnt      = 0;
      bit_buf      = '0;
      bit_fill     = 0;
      emitted      = '0;
      pad_odd      = 1'b0;
      ovf_flag     = 1'b0;
      bad_flag     = 1'b0;
      errors_o     = 0;
      codeword_q.delete();
      burst_q.delete();
    end else begin
      // compare first: a word accepted at this edge yields codewords later
      if (m_tvalid_i && m_tready_i) begin
        if (codeword_q.size() == 0) begin
          $error("codeword 0x%02h arrived with nothing expected", m_tdata_i);
          errors_o++;
        end else begin
          want = codeword_q.pop_front();
          check_field("out_byte", want.data, m_tdata_i);
          check_field("run_last", want.last, m_tlast_i);
          check_field("symbol_done", want.done, m_tuser_i[0]);
          check_field("overflow", want.ovf, m_tuser_i[1]);
          check_field("bad_char", want.bad, m_tuser_i[2]);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[3:2]))
          REG_CNT_NUMERIC: cnt_bits_num = pwdata_i[3:0];
          REG_CNT_ALNUM:   cnt_bits_aln = pwdata_i[3:0];
          REG_CNT_BYTE:    cnt_bits_byt = pwdata_i[4:0];
          default:         cap_reg      = pwdata_i[11:0];
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        pack_word(cmd_e'(s_tuser_i[1:0]), s_tuser_i[3:2], s_tdata_i[15:0],
                  s_tdata_i[23:16]);
      end
    end
    pending_o = codeword_q.size();
  end

endmodule

### tb/sv/tb_qr_data_segment_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR data segment bit packer testbench
// Sends start, character, finish and pad words in bursts while the codeword
// sink stalls, through several count widths and capacities; the checker
// beside the block predicts and compares every codeword.
// ----------------------------------------------------------------------------
module tb_qr_data_segment_bit_packer;
  import qrpack_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;    // block answers in the cycle after it takes a word
  localparam int unsigned RANDOM_WORDS = 48;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned CAP_HEADROOM = 12;   // bytes left before the symbol fills
  localparam logic [1:0]  MODE_RESERVED = 2'd3;
  localparam string       ALNUM_EXTRA  = " $%*+-./:";

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // [15:0] char_count, [23:16] char_value
  logic [3:0]  s_tuser;    // [1:0] cmd, [3:2] seg_mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;    // [7:0] out_byte
  logic        m_tlast;
  logic [2:0]  m_tuser;    // [0] symbol_done, [1] overflow, [2] bad_char
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int pending;       // codewords the checker still waits for
  int mismatches;
  int words_sent;
  int burst_left;
  int bytes_seen;    // every codeword taken so far
  int cycle_count;
  int rx_tick;

  qr_data_segment_bit_packer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast),
    .m_tuser_o  (m_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  qr_packer_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tlast_i  (m_tlast),
    .m_tuser_i  (m_tuser),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .pending_o  (pending),
    .errors_o   (mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sink: rotate through always ready, mostly ready, mostly stalled and a
  // fixed 3-of-8 pattern so stalls land on every codeword of a burst.
  always @(negedge clk) begin
    case ((rx_tick / 80) % 4)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((rx_tick % 8) >= 5);
    endcase
    rx_tick <= rx_tick + 1;
  end

  // Count codewords and stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (m_tvalid && m_tready) bytes_seen <= bytes_seen + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it. Words go out in
  // bursts; between most bursts tvalid drops for a random gap.
  task automatic send_word(input cmd_e cmd, input logic [1:0] mode,
                           input logic [15:0] count, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {ch, count};
    s_tuser  <= {mode, cmd};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Character word; mode and count are ignored there, so fill them with noise.
  task automatic send_char(input logic [7:0] ch);
    send_word(CMD_CHAR, 2'($urandom), 16'($urandom), ch);
  endtask

  task automatic send_cmd(input cmd_e cmd);
    send_word(cmd, 2'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Drop tvalid, wait until every codeword is in, then let the block settle.
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input reg_e idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_registers(input logic [3:0] num, input logic [3:0] aln,
                               input logic [4:0] byt, input logic [11:0] cap);
    apb_write(REG_CNT_NUMERIC, {28'd0, num});
    apb_write(REG_CNT_ALNUM, {28'd0, aln});
    apb_write(REG_CNT_BYTE, {27'd0, byt});
    apb_write(REG_CAPACITY, {20'd0, cap});
  endtask

  // Mostly legal characters for the mode, one in ten a raw random byte.
  function automatic logic [7:0] pick_char(input logic [1:0] mode);
    int code;
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    case (mode)
      MODE_NUMERIC: return 8'("0" + $urandom_range(0, 9));
      MODE_ALNUM: begin
        code = $urandom_range(0, 44);
        if (code < 10) return 8'("0" + code);
        if (code < 36) return 8'("A" + code - 10);
        return ALNUM_EXTRA[code - 36];
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // Well-formed segment with random content, salted with stray commands and
  // an occasional missing finish.
  task automatic random_segment();
    logic [1:0]  mode;
    logic [15:0] count;
    int          nchars;
    mode   = 2'($urandom);
    nchars = $urandom_range(0, 7);
    count  = $urandom_range(0, 1) ? 16'(nchars) : 16'($urandom);
    send_word(CMD_START, mode, count, 8'($urandom));
    for (int i = 0; i < nchars; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_word(cmd_e'(2'($urandom)), 2'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        send_char(pick_char(mode));
      end
    end
    if ($urandom_range(0, 9) != 0) send_cmd(CMD_FINISH);
    repeat ($urandom_range(0, 2)) send_cmd(CMD_PAD);
  endtask

  initial begin
    int phase_stop;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset register values.
    // Numeric: count wider than the field, one full group, then a lone
    // trailing zero digit that must survive as a 4-bit group.
    send_word(CMD_START, MODE_NUMERIC, 16'hFFFF, 8'h00);
    send_char("0");
    send_char("9");
    send_char("9");
    send_char("0");
    send_cmd(CMD_FINISH);
    send_cmd(CMD_PAD);
    send_cmd(CMD_PAD);
    // Alphanumeric pair with a special character, then a half pair that the
    // next start throws away.
    send_word(CMD_START, MODE_ALNUM, 16'd3, 8'hFF);
    send_char("A");
    send_char(":");
    send_char(" ");
    send_word(CMD_START, MODE_BYTE, 16'd0, 8'h00);
    send_char(8'h00);
    send_char(8'hFF);
    send_cmd(CMD_PAD);
    send_cmd(CMD_FINISH);
    // Reserved mode code packs as bytes.
    send_word(CMD_START, MODE_RESERVED, 16'd1, 8'h00);
    send_char(8'h7F);
    send_cmd(CMD_FINISH);
    // Illegal characters in both grouped modes raise bad_char.
    send_word(CMD_START, MODE_NUMERIC, 16'd1, 8'h00);
    send_char("A");
    send_word(CMD_START, MODE_ALNUM, 16'd1, 8'h00);
    send_char("a");
    send_cmd(CMD_FINISH);
    quiesce();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_registers(4'd10, 4'd9, 5'd8, MAX_CAPACITY);
        1: set_registers(4'd15, 4'd15, 5'd31, 12'hFFF);
        2: set_registers(4'($urandom_range(10, 14)), 4'($urandom_range(9, 13)),
                         5'($urandom_range(8, 16)), MAX_CAPACITY);
        // leave a little room so the symbol fills and then overflows
        3: set_registers(4'($urandom), 4'($urandom), 5'($urandom),
                         12'(bytes_seen + CAP_HEADROOM));
        4: set_registers(4'd0, 4'd0, 5'd0, 12'd0);
        default: set_registers(4'($urandom), 4'($urandom), 5'($urandom), 12'hFFF);
      endcase
      phase_stop = words_sent + RANDOM_WORDS / PHASES + 1;
      while (words_sent < phase_stop) random_segment();
      if (ph == 3) begin
        // close the segment and pad up to capacity; the tail raises overflow
        send_cmd(CMD_FINISH);
        repeat (CAP_HEADROOM) send_cmd(CMD_PAD);
        random_segment();
      end
      quiesce();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/qrpack_pkg.sv
rtl/qrpack_encoder.sv
rtl/qrpack_slicer.sv
rtl/qrpack_burst.sv
rtl/qr_data_segment_bit_packer.sv
tb/sv/qr_packer_checker.sv
tb/sv/tb_qr_data_segment_bit_packer.sv
